[hdl/rsc_pkg.sv]
package rsc_pkg;

    localparam int TEXTURE_SIZE = 256;
    localparam int OCTAVE_COUNT = 4;

    localparam int STAGES      = 11;
    localparam int SQRT_GROUPS = 6;

    localparam int TEX_SHIFT = $clog2(TEXTURE_SIZE) + 1;
    localparam int U_MAX     = ((2 * 255 + 1) * 65536) / (2 * TEXTURE_SIZE);
    localparam int U_W       = ($clog2(U_MAX + 1) > 16) ? $clog2(U_MAX + 1) : 16;
    localparam int P_W       = U_W + 3;
    localparam int IDX_W     = P_W + OCTAVE_COUNT - 1 - 16;
    localparam int Q_W       = 17;

    localparam int SQRT_ITERS      = U_W + 1;
    localparam int SQ_W            = 2 * SQRT_ITERS;
    localparam int ITERS_PER_GROUP = (SQRT_ITERS + SQRT_GROUPS - 1) / SQRT_GROUPS;
    localparam int R_W             = SQRT_ITERS + 1;

    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MIX   = 32'd1274126177;
    localparam logic [23:0] HASH_FULL  = 24'hFFFFFF;

    localparam int WSUM       = (1 << OCTAVE_COUNT) - 1;
    localparam int TOT_W      = 17 + OCTAVE_COUNT;
    localparam int NORM_SHIFT = TOT_W + OCTAVE_COUNT;
    localparam int NORM_MUL_W = NORM_SHIFT + 1;
    localparam int NORM_PROD_W = TOT_W + NORM_MUL_W;
    localparam logic [NORM_MUL_W-1:0] NORM_MUL =
        NORM_MUL_W'(((64'd1 << NORM_SHIFT) + 64'(WSUM) - 64'd1) / 64'(WSUM));

    localparam int EDGE_BASE  = 40632;
    localparam int BAND_WIDTH = 19661;
    localparam int BAND_SHIFT = 30;
    localparam logic [31:0] BAND_MUL =
        32'(((64'd1 << 46) + 64'(BAND_WIDTH) - 64'd1) / 64'(BAND_WIDTH));
    localparam int DIFF_W = ((R_W > 18) ? R_W : 18) + 1;

    typedef enum logic [1:0] {
        CFG_NOISE_SEED = 2'd0,
        CFG_RAGGEDNESS = 2'd1
    } cfg_index_e;

    typedef logic [STAGES-1:0] stage_vec_t;

    typedef struct packed {
        logic [7:0] texel_x;
        logic [7:0] texel_y;
    } texel_t;

    typedef struct packed {
        logic [7:0]  coverage_byte;
        logic [15:0] noise_sample;
    } result_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } sqrt_state_t;

    function automatic logic [31:0] hash_mix(input logic [31:0] h0);
        logic [31:0] x;
        x = h0 ^ (h0 >> 13);
        return x * HASH_MIX;
    endfunction

    function automatic logic [Q_W-1:0] lattice_value(input logic [31:0] h1);
        logic [23:0] h2;
        logic [39:0] nv;
        logic [24:0] chk;
        h2  = h1[23:0] ^ {8'h00, h1[31:16]};
        nv  = {h2, 16'h0000} + 40'h7FFFFF;
        chk = 25'(nv[39:24]) + 25'(nv[23:0]);
        return (chk >= 25'(HASH_FULL)) ? Q_W'(nv[39:24]) + Q_W'(1) : Q_W'(nv[39:24]);
    endfunction

    function automatic logic [Q_W-1:0] fade_finish(input logic [15:0] t,
                                                  input logic [15:0] t2);
        logic [17:0] m;
        logic [33:0] p;
        m = 18'd196608 - (18'(t) << 1);
        p = 34'(t2) * 34'(m);
        return p[32:16];
    endfunction

    function automatic logic [Q_W-1:0] blend(input logic [Q_W-1:0] a,
                                            input logic [Q_W-1:0] b,
                                            input logic [Q_W-1:0] s);
        logic [Q_W-1:0] w;
        logic [34:0]    sum;
        w   = Q_W'(65536) - s;
        sum = 35'(a) * 35'(w) + 35'(b) * 35'(s);
        return sum[32:16];
    endfunction

    function automatic sqrt_state_t sqrt_step(input sqrt_state_t st,
                                              input logic [SQ_W-1:0] bitv);
        sqrt_state_t r;
        logic [SQ_W-1:0] trial;
        trial = st.res + bitv;
        if (st.rem >= trial)
        begin
            r.rem = st.rem - trial;
            r.res = (st.res >> 1) + bitv;
        end
        else
        begin
            r.rem = st.rem;
            r.res = st.res >> 1;
        end
        return r;
    endfunction

endpackage

[hdl/ragged_splat_coverage_top.sv]
// Ragged stain mask generator, one texel per item.
// texel channel: texel_valid/texel_ready with texel (texel_x, texel_y).
// result channel: result_valid/result_ready with result (coverage_byte,
// noise_sample). cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 writes noise_seed, index 1 writes raggedness (low 8 bits), any other
// index is dropped. cfg_ready is always high; write only while the pipeline
// holds no item.
// Throughput: one texel per cycle while nothing stalls, set by the eleven register
// stages (lattice hash, smoothstep, interpolation, octave sum, normalise,
// square root spread over six stages, edge and coverage).
// Stalls: each stage advances when it is empty or the stage after it moves, so
// bubbles close up and texel_ready drops only when every stage holds an item
// and result_ready is low. Nothing is lost or repeated.
// Reset: all stage valids clear; noise_seed returns to 11, raggedness to 141.
module ragged_splat_coverage_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             texel_valid,
    output logic             texel_ready,
    input  rsc_pkg::texel_t  texel,
    output logic             result_valid,
    input  logic             result_ready,
    output rsc_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import rsc_pkg::*;

    stage_vec_t   vld_reg;
    stage_vec_t   en;
    logic [31:0]  noise_seed_reg;
    logic [7:0]   raggedness_reg;
    logic [P_W-1:0] px_reg;
    logic [P_W-1:0] py_reg;
    logic [U_W-1:0] dx_reg;
    logic [U_W-1:0] dy_reg;
    logic [P_W-1:0] px_next;
    logic [P_W-1:0] py_next;
    logic [U_W-1:0] dx_next;
    logic [U_W-1:0] dy_next;
    logic [15:0]    noise;
    logic [R_W-1:0] radius;

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
            en[k] = result_ready || !(&(vld_reg | stage_vec_t'((1 << k) - 1)));
    end

    always_comb
    begin
        logic [24:0]    fu;
        logic [24:0]    fv;
        logic [U_W-1:0] u;
        logic [U_W-1:0] v;
        fu = {texel.texel_x, 1'b1, 16'h0000} >> TEX_SHIFT;
        fv = {texel.texel_y, 1'b1, 16'h0000} >> TEX_SHIFT;
        u  = fu[U_W-1:0];
        v  = fv[U_W-1:0];
        px_next = (P_W'(u) << 2) + (P_W'(u) << 1);
        py_next = (P_W'(v) << 2) + (P_W'(v) << 1);
        dx_next = (u >= U_W'(32768)) ? u - U_W'(32768) : U_W'(32768) - u;
        dy_next = (v >= U_W'(32768)) ? v - U_W'(32768) : U_W'(32768) - v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            noise_seed_reg <= 32'd11;
            raggedness_reg <= 8'd141;
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= texel_valid;
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
            if (cfg_valid && cfg_index == CFG_NOISE_SEED)
                noise_seed_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_RAGGEDNESS)
                raggedness_reg <= cfg_data[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    rsc_noise u_noise (
        .clk        (clk),
        .en         (en),
        .px         (px_reg),
        .py         (py_reg),
        .noise_seed (noise_seed_reg),
        .noise      (noise)
    );

    rsc_sqrt u_sqrt (
        .clk    (clk),
        .en     (en),
        .dx     (dx_reg),
        .dy     (dy_reg),
        .radius (radius)
    );

    rsc_cover u_cover (
        .clk        (clk),
        .en         (en),
        .noise      (noise),
        .radius     (radius),
        .raggedness (raggedness_reg),
        .result     (result)
    );

    assign texel_ready  = en[0];
    assign result_valid = vld_reg[STAGES-1];
    assign cfg_ready    = 1'b1;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        texel_valid && texel_ready |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !texel_ready |-> (&vld_reg) && !result_ready)
        else $error("input stalled with a free stage");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(vld_reg[STAGES-2]))
        else $error("result appeared without an item behind it");

    a_ragg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == CFG_RAGGEDNESS |=> raggedness_reg == $past(cfg_data[7:0]))
        else $error("raggedness write lost");
`endif

endmodule

[hdl/rsc_noise.sv]
module rsc_noise (
    input  logic                  clk,
    input  rsc_pkg::stage_vec_t   en,
    input  logic [rsc_pkg::P_W-1:0] px,
    input  logic [rsc_pkg::P_W-1:0] py,
    input  logic [31:0]           noise_seed,
    output logic [15:0]           noise
);
    import rsc_pkg::*;

    logic [31:0]    h0_reg  [OCTAVE_COUNT][4];
    logic [31:0]    h0_next [OCTAVE_COUNT][4];
    logic [15:0]    tx_reg  [OCTAVE_COUNT];
    logic [15:0]    ty_reg  [OCTAVE_COUNT];
    logic [15:0]    t2x_reg [OCTAVE_COUNT];
    logic [15:0]    t2y_reg [OCTAVE_COUNT];
    logic [15:0]    tx_next [OCTAVE_COUNT];
    logic [15:0]    ty_next [OCTAVE_COUNT];
    logic [15:0]    t2x_next[OCTAVE_COUNT];
    logic [15:0]    t2y_next[OCTAVE_COUNT];
    logic [31:0]    h1_reg  [OCTAVE_COUNT][4];
    logic [Q_W-1:0] sx2_reg [OCTAVE_COUNT];
    logic [Q_W-1:0] sy2_reg [OCTAVE_COUNT];
    logic [Q_W-1:0] lat_reg [OCTAVE_COUNT][4];
    logic [Q_W-1:0] sx3_reg [OCTAVE_COUNT];
    logic [Q_W-1:0] sy3_reg [OCTAVE_COUNT];
    logic [Q_W-1:0] top_reg [OCTAVE_COUNT];
    logic [Q_W-1:0] bot_reg [OCTAVE_COUNT];
    logic [Q_W-1:0] sy4_reg [OCTAVE_COUNT];
    logic [Q_W-1:0] oct_reg [OCTAVE_COUNT];
    logic [TOT_W-1:0] total_reg;
    logic [TOT_W-1:0] total_next;
    logic [15:0]    n_reg;
    logic [15:0]    n_next;

    always_comb
    begin
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] hx0;
        logic [31:0] hy0;
        logic [31:0] sqx;
        logic [31:0] sqy;
        for (int o = 0; o < OCTAVE_COUNT; o++)
        begin
            fx  = 32'(px) << o;
            fy  = 32'(py) << o;
            hx0 = 32'(fx[16 +: IDX_W]) * HASH_MUL_X;
            hy0 = 32'(fy[16 +: IDX_W]) * HASH_MUL_Y;
            h0_next[o][0] = hx0 + hy0 + noise_seed;
            h0_next[o][1] = hx0 + HASH_MUL_X + hy0 + noise_seed;
            h0_next[o][2] = hx0 + hy0 + HASH_MUL_Y + noise_seed;
            h0_next[o][3] = hx0 + HASH_MUL_X + hy0 + HASH_MUL_Y + noise_seed;
            tx_next[o]  = fx[15:0];
            ty_next[o]  = fy[15:0];
            sqx = 32'(fx[15:0]) * 32'(fx[15:0]);
            sqy = 32'(fy[15:0]) * 32'(fy[15:0]);
            t2x_next[o] = sqx[31:16];
            t2y_next[o] = sqy[31:16];
        end
    end

    always_comb
    begin
        total_next = TOT_W'(WSUM / 2);
        for (int o = 0; o < OCTAVE_COUNT; o++)
            total_next = total_next + (TOT_W'(oct_reg[o]) << (OCTAVE_COUNT - 1 - o));
    end

    always_comb
    begin
        logic [NORM_PROD_W-1:0] prod;
        logic [16:0]            q;
        prod   = NORM_PROD_W'(total_reg) * NORM_PROD_W'(NORM_MUL);
        q      = prod[NORM_SHIFT +: 17];
        n_next = q[16] ? 16'hFFFF : q[15:0];
    end

    always_ff @(posedge clk)
    begin
        for (int o = 0; o < OCTAVE_COUNT; o++)
        begin
            if (en[1])
            begin
                for (int c = 0; c < 4; c++)
                    h0_reg[o][c] <= h0_next[o][c];
                tx_reg[o]  <= tx_next[o];
                ty_reg[o]  <= ty_next[o];
                t2x_reg[o] <= t2x_next[o];
                t2y_reg[o] <= t2y_next[o];
            end
            if (en[2])
            begin
                for (int c = 0; c < 4; c++)
                    h1_reg[o][c] <= hash_mix(h0_reg[o][c]);
                sx2_reg[o] <= fade_finish(tx_reg[o], t2x_reg[o]);
                sy2_reg[o] <= fade_finish(ty_reg[o], t2y_reg[o]);
            end
            if (en[3])
            begin
                for (int c = 0; c < 4; c++)
                    lat_reg[o][c] <= lattice_value(h1_reg[o][c]);
                sx3_reg[o] <= sx2_reg[o];
                sy3_reg[o] <= sy2_reg[o];
            end
            if (en[4])
            begin
                top_reg[o] <= blend(lat_reg[o][0], lat_reg[o][1], sx3_reg[o]);
                bot_reg[o] <= blend(lat_reg[o][2], lat_reg[o][3], sx3_reg[o]);
                sy4_reg[o] <= sy3_reg[o];
            end
            if (en[5])
                oct_reg[o] <= blend(top_reg[o], bot_reg[o], sy4_reg[o]);
        end
        if (en[6])
            total_reg <= total_next;
        if (en[7])
            n_reg <= n_next;
    end

    assign noise = n_reg;

endmodule

[hdl/rsc_sqrt.sv]
module rsc_sqrt (
    input  logic                    clk,
    input  rsc_pkg::stage_vec_t     en,
    input  logic [rsc_pkg::U_W-1:0] dx,
    input  logic [rsc_pkg::U_W-1:0] dy,
    output logic [rsc_pkg::R_W-1:0] radius
);
    import rsc_pkg::*;

    sqrt_state_t st_reg [SQRT_GROUPS+1];
    sqrt_state_t init_next;

    always_comb
    begin
        init_next.rem = SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy);
        init_next.res = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            st_reg[0] <= init_next;
    end

    for (genvar g = 0; g < SQRT_GROUPS; g++)
    begin : g_grp
        sqrt_state_t st_next;

        always_comb
        begin
            st_next = st_reg[g];
            for (int j = 0; j < ITERS_PER_GROUP; j++)
            begin
                if (g * ITERS_PER_GROUP + j < SQRT_ITERS)
                    st_next = sqrt_step(st_next, SQ_W'(1) <<
                        (2 * (SQRT_ITERS - 1 - (g * ITERS_PER_GROUP + j))));
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[2+g])
                st_reg[g+1] <= st_next;
        end
    end

    assign radius = R_W'(st_reg[SQRT_GROUPS].res) << 1;

endmodule

[hdl/rsc_cover.sv]
module rsc_cover (
    input  logic                    clk,
    input  rsc_pkg::stage_vec_t     en,
    input  logic [15:0]             noise,
    input  logic [rsc_pkg::R_W-1:0] radius,
    input  logic [7:0]              raggedness,
    output rsc_pkg::result_t        result
);
    import rsc_pkg::*;

    logic        pos_reg;
    logic        sat_reg;
    logic [14:0] small_reg;
    logic [15:0] n8_reg;
    logic [16:0] cov_reg;
    logic [16:0] cov_next;
    logic [15:0] n9_reg;
    result_t     result_reg;
    result_t     result_next;
    logic        pos_next;
    logic        sat_next;
    logic [DIFF_W-1:0] diff;

    always_comb
    begin
        logic [15:0] mag;
        logic [23:0] off;
        logic [17:0] edge_q;
        mag = noise[15] ? {1'b0, noise[14:0]} : 16'h8000 - noise;
        off = 24'(raggedness) * 24'(mag);
        edge_q = noise[15] ? 18'(EDGE_BASE) + 18'(off[23:8])
                           : 18'(EDGE_BASE) - 18'(off[23:8]);
        diff     = DIFF_W'(edge_q) - DIFF_W'(radius);
        pos_next = !diff[DIFF_W-1] && (diff != '0);
        sat_next = !diff[DIFF_W-1] && (diff >= DIFF_W'(BAND_WIDTH));
    end

    always_comb
    begin
        logic [46:0] prod;
        prod = 47'(small_reg) * 47'(BAND_MUL);
        if (!pos_reg)
            cov_next = '0;
        else if (sat_reg)
            cov_next = 17'h10000;
        else
            cov_next = {1'b0, prod[BAND_SHIFT +: 16]};
    end

    always_comb
    begin
        logic [24:0] scaled;
        scaled = (25'(cov_reg) << 8) - 25'(cov_reg) + 25'd32768;
        result_next.coverage_byte = scaled[23:16];
        result_next.noise_sample  = n9_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            pos_reg   <= pos_next;
            sat_reg   <= sat_next;
            small_reg <= diff[14:0];
            n8_reg    <= noise;
        end
        if (en[9])
        begin
            cov_reg <= cov_next;
            n9_reg  <= n8_reg;
        end
        if (en[10])
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule
